// ===== rtl/rfge_pkg.sv =====
// shared types, constants and gradient arithmetic for the rgb gradient edge block
package rfge_pkg;

  // frame geometry
  localparam int MaxWidth = 256;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 12;
  localparam int MaxRows  = 4096;
  localparam int WidthW   = 9;
  localparam int HeightW  = 13;
  localparam int CfgW     = 13;
  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // configuration reset values
  localparam logic [WidthW-1:0]  WIDTH_RESET  = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] HEIGHT_RESET = HeightW'(1);

  // bit positions of the pending-result mask
  localparam int MASK_ABOVE = 0;
  localparam int MASK_LEFT  = 1;
  localparam int MASK_SELF  = 2;
  localparam int MaskW      = 3;

  typedef logic [PixW-1:0] pix_t;

  // one queued pixel job with everything the back end needs
  typedef struct packed {
    pix_t             px;
    pix_t             prev;
    pix_t             above;
    pix_t             right;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [MaskW-1:0] mask;
  } cmd_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
  } q_stat_t;

  // rounded-up half of |below - self| + |right - self| for one channel
  function automatic logic [ChanW-1:0] half_grad(input logic [ChanW-1:0] s,
                                                 input logic [ChanW-1:0] b,
                                                 input logic [ChanW-1:0] r);
    logic [ChanW-1:0] db;
    logic [ChanW-1:0] dr;
    logic [ChanW+1:0] sum;
    db  = (b > s) ? (b - s) : (s - b);
    dr  = (r > s) ? (r - s) : (s - r);
    sum = {2'b00, db} + {2'b00, dr} + (ChanW+2)'(1);
    return sum[ChanW:1];
  endfunction

endpackage

// ===== rtl/rfge_front.sv =====
// front end: config registers, raster counters, line buffer and job classification
module rfge_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [rfge_pkg::CfgW-1:0]  cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [rfge_pkg::ChanW-1:0] red_in,
  input  logic [rfge_pkg::ChanW-1:0] green_in,
  input  logic [rfge_pkg::ChanW-1:0] blue_in,
  input  rfge_pkg::q_stat_t       q_stat,
  output logic                    push,
  output rfge_pkg::cmd_t          push_cmd
);
  import rfge_pkg::*;

  logic [WidthW-1:0]  image_width;
  logic [HeightW-1:0] image_height;
  logic [ColW-1:0]    col_count;
  logic [RowW-1:0]    row_count;
  pix_t               prev_pixel;
  pix_t               row_store [MaxWidth];
  pix_t               rd_above;
  pix_t               rd_right;

  logic               s1_valid;
  pix_t               s1_px;
  pix_t               s1_prev;
  logic [RowW-1:0]    s1_row;
  logic [ColW-1:0]    s1_col;
  logic               s1_row_end;
  logic [MaskW-1:0]   s1_mask;

  logic [ColW-1:0]    wm1;
  logic [RowW-1:0]    hm1;
  logic               row_end;
  logic               last_row;
  logic               accept;
  logic               s1_go;
  logic [ColW-1:0]    col_plus1;
  logic [MaskW-1:0]   mask_next;
  pix_t               px;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[WidthW-1:0];
        REG_HEIGHT: image_height <= cfg_data[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // clamped last column and last row
  always_comb begin
    if (image_width == '0) begin
      wm1 = '0;
    end else if (image_width > WidthW'(MaxWidth)) begin
      wm1 = ColW'(MaxWidth - 1);
    end else begin
      wm1 = ColW'(image_width - WidthW'(1));
    end
    if (image_height == '0) begin
      hm1 = '0;
    end else if (image_height > HeightW'(MaxRows)) begin
      hm1 = RowW'(MaxRows - 1);
    end else begin
      hm1 = RowW'(image_height - HeightW'(1));
    end
  end

  // classify the incoming word
  always_comb begin
    px        = {red_in, green_in, blue_in};
    row_end   = col_count >= wm1;
    last_row  = row_count >= hm1;
    col_plus1 = col_count + ColW'(1);
    mask_next = '0;
    mask_next[MASK_ABOVE] = row_count != '0;
    mask_next[MASK_LEFT]  = last_row && (col_count != '0);
    mask_next[MASK_SELF]  = last_row && row_end;
  end

  // handshake between input, stage and queue
  assign s1_go    = s1_valid && ((s1_mask == '0) || !q_stat.full);
  assign in_ready = !s1_valid || s1_go;
  assign accept   = in_valid && in_ready;
  assign push     = s1_valid && (s1_mask != '0) && !q_stat.full;

  // raster counters and left neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      prev_pixel <= '0;
    end else if (accept) begin
      prev_pixel <= px;
      if (row_end && last_row) begin
        col_count <= '0;
        row_count <= '0;
      end else if (row_end) begin
        col_count <= '0;
        row_count <= row_count + RowW'(1);
      end else begin
        col_count <= col_plus1;
      end
    end
  end

  // line buffer: read above and above-right, then overwrite with this pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_above             <= row_store[col_count];
      rd_right             <= row_store[col_plus1];
      row_store[col_count] <= px;
    end
  end

  // stage register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // stage register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= px;
      s1_prev    <= prev_pixel;
      s1_row     <= row_count;
      s1_col     <= col_count;
      s1_row_end <= row_end;
      s1_mask    <= mask_next;
    end
  end

  // job to the queue; at the row end the right neighbor repeats the pixel above
  always_comb begin
    push_cmd.px    = s1_px;
    push_cmd.prev  = s1_prev;
    push_cmd.above = rd_above;
    push_cmd.right = s1_row_end ? rd_above : rd_right;
    push_cmd.row   = s1_row;
    push_cmd.col   = s1_col;
    push_cmd.mask  = s1_mask;
  end

endmodule

// ===== rtl/rfge_queue.sv =====
// two-entry job queue between front end and back end
module rfge_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rfge_pkg::cmd_t    push_cmd,
  output rfge_pkg::q_stat_t q_stat,
  input  logic              pop,
  output logic              head_valid,
  output rfge_pkg::cmd_t    head
);
  import rfge_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.full = count == 2'd2;
  assign head_valid  = count != 2'd0;
  assign head        = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/rfge_back.sv =====
// back end: walks each job's pending results and drives the output register
module rfge_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  rfge_pkg::cmd_t            head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rfge_pkg::ChanW-1:0] edge_red,
  output logic [rfge_pkg::ChanW-1:0] edge_green,
  output logic [rfge_pkg::ChanW-1:0] edge_blue,
  output logic [rfge_pkg::RowW-1:0]  out_row,
  output logic [rfge_pkg::ColW-1:0]  out_col,
  output logic                      run_last,
  output logic                      frame_done
);
  import rfge_pkg::*;

  logic [MaskW-1:0] sent;
  logic [MaskW-1:0] remaining;
  logic [MaskW-1:0] pick;
  logic             last_one;
  logic             load;
  pix_t             op_self;
  pix_t             op_below;
  pix_t             op_right;
  logic [RowW-1:0]  res_row;
  logic [ColW-1:0]  res_col;

  // choose the next result in order above, left, self
  always_comb begin
    remaining = head.mask & ~sent;
    pick      = '0;
    if (remaining[MASK_ABOVE]) begin
      pick[MASK_ABOVE] = 1'b1;
    end else if (remaining[MASK_LEFT]) begin
      pick[MASK_LEFT] = 1'b1;
    end else begin
      pick[MASK_SELF] = 1'b1;
    end
    last_one = (remaining & ~pick) == '0;
  end

  // operands of the chosen result
  always_comb begin
    if (pick[MASK_ABOVE]) begin
      op_self  = head.above;
      op_below = head.px;
      op_right = head.right;
      res_row  = head.row - RowW'(1);
      res_col  = head.col;
    end else if (pick[MASK_LEFT]) begin
      op_self  = head.prev;
      op_below = head.prev;
      op_right = head.px;
      res_row  = head.row;
      res_col  = head.col - ColW'(1);
    end else begin
      op_self  = head.px;
      op_below = head.px;
      op_right = head.px;
      res_row  = head.row;
      res_col  = head.col;
    end
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last_one;

  // progress through the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (load) begin
      sent <= last_one ? '0 : (sent | pick);
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      edge_red   <= half_grad(op_self[23:16], op_below[23:16], op_right[23:16]);
      edge_green <= half_grad(op_self[15:8], op_below[15:8], op_right[15:8]);
      edge_blue  <= half_grad(op_self[7:0], op_below[7:0], op_right[7:0]);
      out_row    <= res_row;
      out_col    <= res_col;
      run_last   <= last_one;
      frame_done <= pick[MASK_SELF];
    end
  end

endmodule

// ===== rtl/rgb_forward_gradient_edge.sv =====
// top level of the streaming rgb forward-gradient edge detector
//
// Pixels enter in raster order on in_valid/in_ready with red_in, green_in,
// blue_in. Frame size comes from the write port: index 0 is the width
// (1..256), index 1 the height (1..4096); write only while the block is idle.
// Each pixel word gives the result for the pixel above it; on the last row it
// also gives the result to its left and, at the row end, its own result.
// Results leave on out_valid/out_ready with row and column, run_last on the
// last word caused by one pixel and frame_done on the bottom-right pixel.
// The first result of a pixel passes through the stage register, the job
// queue and the output register. Throughput: one pixel per cycle while each
// pixel gives at most one result and the receiver takes every word; on the
// last row the single output register sets the pace at one result per cycle.
// The line buffer is a 256 x 24 memory with one write and two reads per pixel.
// Reset empties the pipeline and queue, clears counters and the left pixel,
// and sets width 256, height 1; no clearing pass is needed.
// When the receiver stalls, the output word holds, the two-entry job queue
// fills, and then in_ready drops.
module rgb_forward_gradient_edge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [rfge_pkg::CfgW-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rfge_pkg::ChanW-1:0] red_in,
  input  logic [rfge_pkg::ChanW-1:0] green_in,
  input  logic [rfge_pkg::ChanW-1:0] blue_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rfge_pkg::ChanW-1:0] edge_red,
  output logic [rfge_pkg::ChanW-1:0] edge_green,
  output logic [rfge_pkg::ChanW-1:0] edge_blue,
  output logic [rfge_pkg::RowW-1:0]  out_row,
  output logic [rfge_pkg::ColW-1:0]  out_col,
  output logic                       run_last,
  output logic                       frame_done
);
  import rfge_pkg::*;

  q_stat_t q_stat;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  logic    head_valid;
  cmd_t    head;

  // front end
  rfge_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // job queue
  rfge_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  // back end
  rfge_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .edge_red  (edge_red),
    .edge_green(edge_green),
    .edge_blue (edge_blue),
    .out_row   (out_row),
    .out_col   (out_col),
    .run_last  (run_last),
    .frame_done(frame_done)
  );

endmodule

// ===== sim/rgb_forward_gradient_edge_test.sv =====
// self-checking testbench for the rgb forward-gradient edge detector
`timescale 1ns / 1ps

module rgb_forward_gradient_edge_test;
  import rfge_pkg::*;

  localparam int CycleLimit   = 600_000;
  localparam int RandomPixels = 140;
  localparam int SettleCycles = 8;
  localparam int ReportCap    = 200;

  typedef enum {PIX_NOISE, PIX_RAILS, PIX_SMOOTH} pix_style_e;
  typedef enum {DRAIN_FREE, DRAIN_CHOPPY, DRAIN_CLOGGED} drain_mode_e;

  // one result word as the block should present it
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             run_end;
    logic             frame_end;
  } edge_word_t;

  // shadow of the raster walk plus the edge words still owed by the block
  class edge_board;
    logic [WidthW-1:0]  width_reg;
    logic [HeightW-1:0] height_reg;
    pix_t               line_buf [MaxWidth];
    pix_t               left_px;
    logic [RowW-1:0]    row_cnt;
    logic [ColW-1:0]    col_cnt;
    edge_word_t         pending_edges [$];
    int                 errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      left_px    = '0;
      row_cnt    = '0;
      col_cnt    = '0;
      errors     = 0;
      foreach (line_buf[i]) line_buf[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [CfgW-1:0] value);
      if (idx == REG_WIDTH) width_reg = value[WidthW-1:0];
      else height_reg = value[HeightW-1:0];
    endfunction

    function int pending();
      return pending_edges.size();
    endfunction

    function bit at_frame_start();
      return row_cnt == 0 && col_cnt == 0;
    endfunction

    // ceil of half the two forward differences for one channel
    function logic [ChanW-1:0] rounded_half(int s, int b, int r);
      int sum;
      sum = ((b > s) ? b - s : s - b) + ((r > s) ? r - s : s - r);
      return ChanW'((sum + 1) / 2);
    endfunction

    function edge_word_t grade(pix_t self_px, pix_t below, pix_t right_px,
                               int unsigned row, int unsigned col);
      edge_word_t w;
      w.red       = rounded_half(int'(self_px[23:16]), int'(below[23:16]),
                                 int'(right_px[23:16]));
      w.green     = rounded_half(int'(self_px[15:8]), int'(below[15:8]),
                                 int'(right_px[15:8]));
      w.blue      = rounded_half(int'(self_px[7:0]), int'(below[7:0]),
                                 int'(right_px[7:0]));
      w.row       = RowW'(row);
      w.col       = ColW'(col);
      w.run_end   = 1'b0;
      w.frame_end = 1'b0;
      return w;
    endfunction

    // expected words for one accepted pixel, then advance the raster position
    function void take_pixel(pix_t px);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      bit          row_end;
      bit          last_row;
      pix_t        above;
      pix_t        right_px;
      edge_word_t  tail;
      edge_word_t  words [$];
      w = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MaxRows) ? MaxRows : height_reg;
      col      = col_cnt;
      row      = row_cnt;
      row_end  = col >= w - 1;
      last_row = row >= h - 1;
      // pixel above is complete once its lower neighbor arrives
      if (row > 0) begin
        above    = line_buf[col];
        right_px = row_end ? above : line_buf[col + 1];
        words.insert(words.size(), grade(above, px, right_px, row - 1, col));
      end
      // bottom row closes pixels from the left, and itself at the row end
      if (last_row) begin
        if (col > 0) words.insert(words.size(), grade(left_px, left_px, px, row, col - 1));
        if (row_end) begin
          tail = grade(px, px, px, row, col);
          tail.frame_end = 1'b1;
          words.insert(words.size(), tail);
        end
      end
      // last word of this pixel closes its run
      if (words.size() > 0) begin
        tail = words[words.size() - 1];
        tail.run_end = 1'b1;
        words[words.size() - 1] = tail;
      end
      foreach (words[i]) pending_edges.insert(pending_edges.size(), words[i]);
      line_buf[col] = px;
      left_px = px;
      if (row_end && last_row) begin
        row_cnt = '0;
        col_cnt = '0;
      end else if (row_end) begin
        row_cnt = row_cnt + RowW'(1);
        col_cnt = '0;
      end else begin
        col_cnt = col_cnt + ColW'(1);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= ReportCap) $display("%s", msg);
    endtask

    task match_edge(edge_word_t got);
      edge_word_t want;
      if (pending_edges.size() == 0) begin
        report($sformatf("unexpected word at row %0d col %0d", got.row, got.col));
        return;
      end
      want = pending_edges.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.row !== want.row || got.col !== want.col ||
          got.run_end !== want.run_end || got.frame_end !== want.frame_end)
        report($sformatf({"word mismatch: got %0d/%0d/%0d (%0d,%0d) last %b done %b,",
                          " want %0d/%0d/%0d (%0d,%0d) last %b done %b"},
                         got.red, got.green, got.blue, got.row, got.col,
                         got.run_end, got.frame_end,
                         want.red, want.green, want.blue, want.row, want.col,
                         want.run_end, want.frame_end));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_WIDTH;
  logic [CfgW-1:0]  cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [ChanW-1:0] red_in    = '0;
  logic [ChanW-1:0] green_in  = '0;
  logic [ChanW-1:0] blue_in   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ChanW-1:0] edge_red;
  logic [ChanW-1:0] edge_green;
  logic [ChanW-1:0] edge_blue;
  logic [RowW-1:0]  out_row;
  logic [ColW-1:0]  out_col;
  logic             run_last;
  logic             frame_done;

  edge_board   board;
  pix_t        last_px     = '0;
  int          burst_left  = 0;
  bit          steady_feed = 1'b0;
  int          pixels_sent = 0;
  int          cycle_count = 0;
  drain_mode_e drain_mode  = DRAIN_FREE;
  int          drain_phase = 0;
  int          hold_left   = 0;

  rgb_forward_gradient_edge dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, switching between free, choppy and clogged spells
  always @(negedge clk) begin
    if (drain_phase == 0) begin
      drain_mode  = drain_mode_e'($urandom_range(0, 2));
      drain_phase = $urandom_range(40, 300);
    end
    drain_phase--;
    if (hold_left > 0) hold_left--;
    else if (drain_mode == DRAIN_CHOPPY && $urandom_range(0, 2) == 0)
      hold_left = $urandom_range(1, 3);
    else if (drain_mode == DRAIN_CLOGGED && $urandom_range(0, 5) == 0)
      hold_left = $urandom_range(4, 16);
    out_ready <= (hold_left == 0);
  end

  // check every word the block hands over
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.match_edge(edge_word_t'({edge_red, edge_green, edge_blue, out_row, out_col,
                                     run_last, frame_done}));
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic pix_t next_pixel(input pix_style_e style);
    pix_t px;
    int   v;
    case (style)
      PIX_RAILS: begin
        for (int k = 0; k < 3; k++) px[8*k +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end
      PIX_SMOOTH: begin
        for (int k = 0; k < 3; k++) begin
          v = int'(last_px[8*k +: 8]) + $urandom_range(0, 8) - 4;
          px[8*k +: 8] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : 8'(v);
        end
      end
      default: px = pix_t'($urandom);
    endcase
    last_px = px;
    return px;
  endfunction

  // send one pixel word; bursts of random length with random gaps between
  task automatic push_pixel(input pix_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_feed ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    {red_in, green_in, blue_in} <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_pixel(px);
    pixels_sent++;
  endtask

  // stop sending, wait for every owed word, then let the pipeline drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgW'(value);
    @(posedge clk);
    board.set_reg(idx, CfgW'(value));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame(input pix_style_e style);
    do push_pixel(next_pixel(style));
    while (!board.at_frame_start());
  endtask

  initial begin
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned size;
    int unsigned cut_at;
    int          random_start;
    pix_style_e  style;
    board = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset geometry: one 256-wide row, cut short mid-row by a narrower width
    push_pixel(24'hFF00FF);
    push_pixel(24'h00FF00);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h000000);
    settle();
    write_reg(REG_WIDTH, 3);
    run_frame(PIX_RAILS);

    // zero width with junk above the register bits acts as one column
    settle();
    write_reg(REG_WIDTH, 13'h1E00);
    write_reg(REG_HEIGHT, 3);
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h01FE80);

    // zero height acts as one row
    settle();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 0);
    push_pixel(24'h80FF01);
    push_pixel(24'h7F00FE);

    // height past the top clamps; a lower height then ends the frame early
    settle();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 13'h1FFF);
    repeat (3) push_pixel(next_pixel(PIX_NOISE));
    settle();
    write_reg(REG_HEIGHT, 2);
    run_frame(PIX_NOISE);

    // small frame with odd gradient sums
    settle();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    push_pixel(24'h102030);
    push_pixel(24'h0F0F0F);
    push_pixel(24'h000000);
    push_pixel(24'h112233);
    push_pixel(24'hFF0080);
    push_pixel(24'h7F7F7F);

    // widest row, width register at or past the top
    settle();
    write_reg(REG_WIDTH, $urandom_range(MaxWidth, 511));
    write_reg(REG_HEIGHT, 1);
    run_frame(PIX_NOISE);

    // random frames, some resized mid-frame
    random_start = pixels_sent;
    while (pixels_sent - random_start < RandomPixels) begin
      case ($urandom_range(0, 9))
        0:       w_raw = 0;
        1, 2:    w_raw = $urandom_range(9, 24);
        default: w_raw = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       h_raw = 0;
        1:       h_raw = $urandom_range(6, 8);
        2:       h_raw = $urandom_range(MaxRows, 8191);
        default: h_raw = $urandom_range(1, 5);
      endcase
      w_eff = (w_raw == 0) ? 1 : w_raw;
      h_eff = (h_raw == 0) ? 1 : (h_raw > MaxRows) ? MaxRows : h_raw;
      size  = w_eff * h_eff;
      style = pix_style_e'($urandom_range(0, 2));
      steady_feed = ($urandom_range(0, 3) == 0);
      settle();
      // bits above the width register are don't-care
      if ($urandom_range(0, 3) == 0) write_reg(REG_WIDTH, w_raw | ($urandom_range(1, 15) << WidthW));
      else write_reg(REG_WIDTH, w_raw);
      write_reg(REG_HEIGHT, h_raw);
      // tall frames always get cut; others now and then
      if (h_eff > 8 || (size > 1 && $urandom_range(0, 3) == 0)) begin
        cut_at = $urandom_range(1, (size - 1 < 40) ? size - 1 : 40);
        repeat (cut_at) push_pixel(next_pixel(style));
        settle();
        if (h_eff > 8 || $urandom_range(0, 1) == 1)
          write_reg(REG_HEIGHT, $urandom_range(1, board.row_cnt + 1));
        else
          write_reg(REG_WIDTH, $urandom_range(1, w_eff));
      end
      run_frame(style);
    end

    settle();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rfge_pkg.sv
rtl/rfge_front.sv
rtl/rfge_queue.sv
rtl/rfge_back.sv
rtl/rgb_forward_gradient_edge.sv
sim/rgb_forward_gradient_edge_test.sv
